// ----- rtl/tle_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types, character codes and the result expansion of the line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

    localparam logic [7:0] MAX_LINE       = 8'd255;
    localparam logic [7:0] MAX_LEN_RESET  = 8'd80;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_BELL  = 8'h07;
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_K     = 8'h4b;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_BELL,
        CMD_BACKSPACE,
        CMD_CLEAR,
        CMD_LINE_END,
        CMD_STORE
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] ch;
        logic [7:0] pos;
    } t_entry;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic       write_valid;
        logic [7:0] write_index;
        logic [7:0] write_byte;
        logic       line_done;
        logic [7:0] line_length;
        logic       last;
    } t_result;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    function automatic logic [7:0] clear_byte(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = CH_ESC;
            3'd1:    b = CH_LBRK;
            3'd2:    b = CH_TWO;
            3'd3:    b = CH_K;
            default: b = CH_CR;
        endcase
        return b;
    endfunction

    function automatic t_result make_result(input t_entry e, input logic [2:0] step);
        t_result r;
        r = '0;
        r.last = 1'b1;
        case (e.cmd)
            CMD_BELL: begin
                r.echo_byte = CH_BELL;
            end
            CMD_BACKSPACE: begin
                r.echo_byte = (step == 3'd1) ? CH_SP : CH_BS;
                r.last      = (step == 3'd2);
            end
            CMD_CLEAR: begin
                r.echo_byte = clear_byte(step);
                r.last      = (step == 3'd4);
            end
            CMD_LINE_END: begin
                r.echo_byte   = CH_SP;
                r.write_valid = 1'b1;
                r.write_index = e.pos;
                r.write_byte  = CH_SP;
                r.line_done   = 1'b1;
                r.line_length = e.pos;
            end
            CMD_STORE: begin
                r.echo_byte   = e.ch;
                r.write_valid = 1'b1;
                r.write_index = e.pos;
                r.write_byte  = e.ch;
            end
            default: begin
                r = '0;
                r.last = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tle_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tle_front
// Accepts received characters, tracks the line position and queues commands.
// ----------------------------------------------------------------------------
module tle_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_wr_en,
    input  wire logic [7:0]     i_cfg_wr_data,
    input  wire logic           i_in_valid,
    input  wire logic [7:0]     i_rx_char,
    input  wire logic           i_queue_full,
    output logic                o_in_stall,
    output logic                o_push,
    output tle_pkg::t_entry     o_entry
);

    logic [7:0]      r_max_length;
    logic [7:0]      r_position;
    logic [7:0]      n_position;
    logic [7:0]      limit;
    logic            accept;
    tle_pkg::t_entry entry;

    assign limit      = (r_max_length > tle_pkg::MAX_LINE) ? tle_pkg::MAX_LINE : r_max_length;
    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;

    always_comb begin
        entry      = '0;
        entry.cmd  = tle_pkg::CMD_NONE;
        entry.ch   = i_rx_char;
        entry.pos  = r_position;
        n_position = r_position;
        if (i_rx_char == tle_pkg::CH_BS) begin
            if (r_position != 8'd0) begin
                entry.cmd  = tle_pkg::CMD_BACKSPACE;
                n_position = r_position - 8'd1;
            end else begin
                entry.cmd = tle_pkg::CMD_BELL;
            end
        end else if (i_rx_char == tle_pkg::CH_DEL) begin
            entry.cmd  = tle_pkg::CMD_CLEAR;
            n_position = 8'd0;
        end else if (i_rx_char == tle_pkg::CH_CR) begin
            entry.cmd  = tle_pkg::CMD_LINE_END;
            n_position = 8'd0;
        end else if (i_rx_char >= tle_pkg::CH_SP && i_rx_char <= tle_pkg::CH_TILDE) begin
            if (r_position >= limit) begin
                entry.cmd = tle_pkg::CMD_BELL;
            end else begin
                entry.cmd  = tle_pkg::CMD_STORE;
                n_position = r_position + 8'd1;
            end
        end
    end

    assign o_push  = accept && (entry.cmd != tle_pkg::CMD_NONE);
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= tle_pkg::MAX_LEN_RESET;
            r_position   <= 8'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_length <= i_cfg_wr_data;
            end
            if (accept) begin
                r_position <= n_position;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tle_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tle_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module tle_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire tle_pkg::t_entry    i_entry,
    input  wire logic               i_pop,
    output tle_pkg::t_entry         o_head,
    output tle_pkg::t_queue_status  o_status
);

    localparam int CW = $clog2(tle_pkg::QUEUE_DEPTH + 1);

    tle_pkg::t_entry              r_slot [tle_pkg::QUEUE_DEPTH];
    logic [tle_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [tle_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [CW-1:0]                r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_status.empty = (r_count == CW'(0));
    assign o_status.full  = (r_count == CW'(tle_pkg::QUEUE_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/tle_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tle_back
// Expands queued commands into echo results, one per cycle unless the output
// is stalled, into an output register.
// ----------------------------------------------------------------------------
module tle_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tle_pkg::t_entry    i_head,
    input  wire tle_pkg::t_queue_status i_status,
    output logic                    o_pop,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tle_pkg::t_result        o_result
);

    tle_pkg::t_entry  r_entry;
    logic [2:0]       r_step;
    logic             r_busy;
    logic             r_out_valid;
    tle_pkg::t_result r_result;
    tle_pkg::t_entry  src;
    logic [2:0]       step;
    tle_pkg::t_result next;
    logic             load;

    assign src  = r_busy ? r_entry : i_head;
    assign step = r_busy ? r_step : 3'd0;
    assign next = tle_pkg::make_result(src, step);
    assign load = (!r_out_valid || !i_out_stall) && (r_busy || !i_status.empty);

    assign o_pop       = load && !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= next;
            r_entry  <= src;
            r_step   <= step + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy      <= !next.last;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/terminal_line_editor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_line_editor
// Line editor for a serial terminal: echoes each received character and
// reports writes into the line buffer and finished lines.
// ----------------------------------------------------------------------------
// Usage:
// Received characters enter on i_rx_char with i_in_valid; a request is taken
// at a clock edge where i_in_valid is high and o_in_stall is low. The front
// end takes one character per cycle while its four-entry command queue has
// room, so o_in_stall rises only when the queue is full.
// Each character gives one, three or five result requests (or none for other
// control bytes), delivered one per cycle while i_out_stall is low from the
// back end's output register with o_out_valid; o_last marks the final result
// of a character. Sustained throughput is set by the back end, which sends one
// result per cycle while i_out_stall is low.
// While i_out_stall is high the current result holds, the queue fills and
// then the input is stalled. max_length is written through i_cfg_wr_en and
// i_cfg_wr_data; the user must write it only while the block is idle, which
// the block itself does not enforce.
// Reset clears the line position, the queue and the output valid flag and
// sets max_length to 80.
// ----------------------------------------------------------------------------
module terminal_line_editor (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_rx_char,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_echo_byte,
    output logic            o_write_valid,
    output logic [7:0]      o_write_index,
    output logic [7:0]      o_write_byte,
    output logic            o_line_done,
    output logic [7:0]      o_line_length,
    output logic            o_last
);

    tle_pkg::t_entry        push_entry;
    tle_pkg::t_entry        head;
    tle_pkg::t_queue_status status;
    tle_pkg::t_result       result;
    logic                   push;
    logic                   pop;

    tle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_rx_char     (i_rx_char),
        .i_queue_full  (status.full),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    tle_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    tle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_status    (status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_echo_byte   = result.echo_byte;
    assign o_write_valid = result.write_valid;
    assign o_write_index = result.write_index;
    assign o_write_byte  = result.write_byte;
    assign o_line_done   = result.line_done;
    assign o_line_length = result.line_length;
    assign o_last        = result.last;

`ifndef NO_ASSERTIONS
    a_queue_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(status.full && status.empty))
        else $error("queue reports full and empty at once");

    a_write_echo : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_valid |-> o_echo_byte == o_write_byte)
        else $error("stored byte differs from echoed byte");

    a_line_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_done |-> o_last && o_write_valid &&
        o_write_index == o_line_length)
        else $error("finished line result is malformed");

    a_pop_not_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !status.empty)
        else $error("back end pops an empty queue");
`endif

endmodule
`default_nettype wire
